### rtl/core/u8dp_pkg.sv
// Shared types and constants of the UTF-8 decoder with position tracking.
package u8dp_pkg;

	localparam int OFFSET_BITS = 24;
	localparam int CP_W        = 21;
	localparam int OUT_OFF_W   = 24;
	localparam int POS_W       = 16;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [CP_W-1:0] CP_NEWLINE = CP_W'(10);
	localparam logic [CP_W-1:0] CP_MIN2    = CP_W'(32'h80);
	localparam logic [CP_W-1:0] CP_MIN3    = CP_W'(32'h800);
	localparam logic [CP_W-1:0] CP_MIN4    = CP_W'(32'h10000);
	localparam logic [CP_W-1:0] CP_MAX     = CP_W'(32'h10FFFF);
	localparam logic [CP_W-1:0] SURR_LO    = CP_W'(32'hD800);
	localparam logic [CP_W-1:0] SURR_HI    = CP_W'(32'hDFFF);

	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef enum logic [1:0] {
		KIND_VALID = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [CP_W-1:0]      cp;
		kind_t                kind;
		logic [OUT_OFF_W-1:0] start;
	} result_t;

	typedef struct packed {
		logic    pair;
		result_t first;
		result_t second;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage

### rtl/core/u8dp_front.sv
// Front end: accept bytes, decode UTF-8 sequences, form result entries.
module u8dp_front import u8dp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic         end_of_input,
	input  fifo_status_t fifo_status,
	output logic         push,
	output entry_t       push_entry
);

	logic [CP_W-1:0]        acc_q, acc_d;
	logic [1:0]             pend_q, pend_d;
	logic [2:0]             len_q, len_d;
	logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
	logic [OFFSET_BITS-1:0] sstart_q, sstart_d;

	logic            lead_emit;
	result_t         lead_res;
	logic [CP_W-1:0] lead_acc;
	logic [1:0]      lead_pend;
	logic [2:0]      lead_len;
	logic [CP_W-1:0] acc_next;
	logic            fire;
	logic            emit0;
	logic            emit1;
	result_t         r0;
	result_t         r1;

	function automatic result_t mk_res(logic [CP_W-1:0] cp, kind_t kind,
			logic [OFFSET_BITS-1:0] start);
		result_t r;
		r.cp    = cp;
		r.kind  = kind;
		r.start = OUT_OFF_W'(start);
		return r;
	endfunction

	function automatic logic value_ok(logic [CP_W-1:0] v, logic [2:0] len);
		logic ok;
		case (len)
			LEN_TWO:   ok = (v >= CP_MIN2);
			LEN_THREE: ok = (v >= CP_MIN3) && ((v < SURR_LO) || (v > SURR_HI));
			LEN_FOUR:  ok = (v >= CP_MIN4) && (v <= CP_MAX);
			default:   ok = 1'b0;
		endcase
		return ok;
	endfunction

	assign in_ready = !fifo_status.full;
	assign fire     = in_valid && in_ready;
	assign acc_next = {acc_q[CP_W-7:0], data_byte[5:0]};

	always_comb begin
		lead_emit = 1'b0;
		lead_res  = mk_res('0, KIND_ERROR, cnt_q);
		lead_acc  = '0;
		lead_pend = 2'd0;
		lead_len  = LEN_NONE;
		unique casez (data_byte)
			8'b0???????: begin
				lead_emit = 1'b1;
				lead_res  = mk_res(CP_W'(data_byte), KIND_VALID, cnt_q);
			end
			8'b110?????: begin
				lead_acc  = CP_W'(data_byte[4:0]);
				lead_pend = 2'd1;
				lead_len  = LEN_TWO;
			end
			8'b1110????: begin
				lead_acc  = CP_W'(data_byte[3:0]);
				lead_pend = 2'd2;
				lead_len  = LEN_THREE;
			end
			8'b11110???: begin
				lead_acc  = CP_W'(data_byte[2:0]);
				lead_pend = 2'd3;
				lead_len  = LEN_FOUR;
			end
			default: begin
				lead_emit = 1'b1;
			end
		endcase
	end

	always_comb begin
		acc_d    = acc_q;
		pend_d   = pend_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		sstart_d = sstart_q;
		emit0    = 1'b0;
		emit1    = 1'b0;
		r0       = mk_res('0, KIND_END, cnt_q);
		r1       = mk_res('0, KIND_END, cnt_q);
		if (end_of_input) begin
			emit0 = 1'b1;
			if (pend_q != 2'd0) begin
				r0     = mk_res('0, KIND_ERROR, sstart_q);
				emit1  = 1'b1;
				pend_d = 2'd0;
				len_d  = LEN_NONE;
				acc_d  = '0;
			end
		end else begin
			cnt_d = cnt_q + OFFSET_BITS'(1);
			if (pend_q != 2'd0 && data_byte[7:6] == 2'b10) begin
				acc_d  = acc_next;
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					emit0 = 1'b1;
					r0    = value_ok(acc_next, len_q) ?
						mk_res(acc_next, KIND_VALID, sstart_q) :
						mk_res('0, KIND_ERROR, sstart_q);
					len_d = LEN_NONE;
					acc_d = '0;
				end
			end else if (pend_q != 2'd0) begin
				emit0    = 1'b1;
				r0       = mk_res('0, KIND_ERROR, sstart_q);
				emit1    = lead_emit;
				r1       = lead_res;
				sstart_d = cnt_q;
				acc_d    = lead_acc;
				pend_d   = lead_pend;
				len_d    = lead_len;
			end else begin
				emit0    = lead_emit;
				r0       = lead_res;
				sstart_d = cnt_q;
				acc_d    = lead_acc;
				pend_d   = lead_pend;
				len_d    = lead_len;
			end
		end
	end

	assign push              = fire && emit0;
	assign push_entry.pair   = emit1;
	assign push_entry.first  = r0;
	assign push_entry.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pend_q   <= 2'd0;
			len_q    <= LEN_NONE;
			cnt_q    <= '0;
			sstart_q <= '0;
		end else if (fire) begin
			acc_q    <= acc_d;
			pend_q   <= pend_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			sstart_q <= sstart_d;
		end
	end

endmodule

### rtl/core/u8dp_fifo.sv
// Short queue of decoded result entries between front and back end.
module u8dp_fifo import u8dp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  entry_t       push_entry,
	input  logic         pop,
	output entry_t       head,
	output fifo_status_t status
);

	entry_t                slot_q [FIFO_DEPTH];
	logic [FIFO_IDX_W-1:0] wr_q;
	logic [FIFO_IDX_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	function automatic logic [FIFO_IDX_W-1:0] bump(logic [FIFO_IDX_W-1:0] p);
		return (p == FIFO_IDX_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_IDX_W'(1);
	endfunction

	assign status.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= bump(wr_q);
			end
			if (do_pop) begin
				rd_q <= bump(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/u8dp_back.sv
// Back end: issue results one per cycle while the receiver accepts them, track row and column, drive output register.
module u8dp_back import u8dp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  entry_t               head,
	input  fifo_status_t         fifo_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CP_W-1:0]      code_point,
	output logic [1:0]           kind,
	output logic [OUT_OFF_W-1:0] start_offset,
	output logic [POS_W-1:0]     row,
	output logic [POS_W-1:0]     column,
	output logic                 last
);

	logic                 valid_q;
	logic                 sel_q;
	logic [POS_W-1:0]     row_q;
	logic [POS_W-1:0]     col_q;
	logic [CP_W-1:0]      cp_q;
	kind_t                kind_q;
	logic [OUT_OFF_W-1:0] start_q;
	logic [POS_W-1:0]     row_out_q;
	logic [POS_W-1:0]     col_out_q;
	logic                 last_q;
	logic                 load;
	result_t              cur;
	logic                 cur_last;
	logic                 is_newline;

	assign load       = !fifo_status.empty && (!valid_q || out_ready);
	assign cur        = sel_q ? head.second : head.first;
	assign cur_last   = !head.pair || sel_q;
	assign pop        = load && cur_last;
	assign is_newline = (cur.kind == KIND_VALID) && (cur.cp == CP_NEWLINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
			row_q   <= POS_ONE;
			col_q   <= POS_ONE;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !cur_last;
				if (is_newline) begin
					if (row_q != POS_MAX) begin
						row_q <= row_q + POS_ONE;
					end
					col_q <= POS_ONE;
				end else if (cur.kind != KIND_END && col_q != POS_MAX) begin
					col_q <= col_q + POS_ONE;
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q      <= cur.cp;
			kind_q    <= cur.kind;
			start_q   <= cur.start;
			row_out_q <= row_q;
			col_out_q <= col_q;
			last_q    <= cur_last;
		end
	end

	assign out_valid    = valid_q;
	assign code_point   = cp_q;
	assign kind         = kind_q;
	assign start_offset = start_q;
	assign row          = row_out_q;
	assign column       = col_out_q;
	assign last         = last_q;

endmodule

### rtl/core/utf8_decoder_with_position.sv
// Top level of the UTF-8 decoder with byte offset, row and column tracking.
// Input channel: one request per byte (data_byte), or an end marker
// (end_of_input high, data_byte ignored). Output channel: one request per
// result: a code point, an encoding error, or an end-of-input result, each
// with start_offset, row and column; last marks the final result of a byte.
// A byte yields zero, one or two results; an end marker one or two.
// Each result passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full, set by the
// combinational decode in the front end; a byte with two results issues
// them to the output one after the other, as the receiver accepts them.
// A four-entry queue sits between decoder and output stage; when the
// receiver stalls, results wait there and in the output register, and
// in_ready drops once the queue is full.
// Reset clears the decode state, offset to zero, row and column to one,
// and empties the queue and output register.
module utf8_decoder_with_position import u8dp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_input,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CP_W-1:0]      code_point,
	output logic [1:0]           kind,
	output logic [OUT_OFF_W-1:0] start_offset,
	output logic [POS_W-1:0]     row,
	output logic [POS_W-1:0]     column,
	output logic                 last
);

	fifo_status_t fifo_status;
	logic         push;
	entry_t       push_entry;
	logic         pop;
	entry_t       head;

	u8dp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_input(end_of_input),
		.fifo_status (fifo_status),
		.push        (push),
		.push_entry  (push_entry)
	);

	u8dp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (fifo_status)
	);

	u8dp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.fifo_status (fifo_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_point  (code_point),
		.kind        (kind),
		.start_offset(start_offset),
		.row         (row),
		.column      (column),
		.last        (last)
	);

endmodule

### rtl/core/u8dp_checker.sv
// Port-level assertions for the UTF-8 decoder, bound to the top level.
module u8dp_checker import u8dp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CP_W-1:0]      code_point,
	input logic [1:0]           kind,
	input logic [OUT_OFF_W-1:0] start_offset,
	input logic [POS_W-1:0]     row,
	input logic [POS_W-1:0]     column,
	input logic                 last
);

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> last && code_point == '0)
		else $error("end result not last or nonzero code point");

	a_error_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> code_point == '0)
		else $error("error result with nonzero code point");

	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row != '0 && column != '0 &&
		(kind == KIND_VALID || kind == KIND_ERROR || kind == KIND_END))
		else $error("bad row, column or kind");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) &&
		$stable(kind) && $stable(start_offset) && $stable(row) &&
		$stable(column) && $stable(last))
		else $error("stalled result changed");

endmodule

bind utf8_decoder_with_position u8dp_checker u_u8dp_checker (.*);

### tb/utf8_decoder_with_position_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 decoder with position tracking, with its own decode predictor.
module utf8_decoder_with_position_test;
	import u8dp_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int LONG_HOLD    = 120;
	localparam int HOLD_AFTER   = 200;
	localparam int RANDOM_ITEMS = 1500;
	localparam int SAT_RUN      = 40;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] LETTER_BYTE  = 8'h61;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		logic       drain;
		logic       quiet;
	} byte_req_t;

	typedef struct packed {
		logic [CP_W-1:0]      cp;
		kind_t                kind;
		logic [OUT_OFF_W-1:0] start;
		logic [POS_W-1:0]     row;
		logic [POS_W-1:0]     column;
		logic                 last;
	} decoded_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte    = 8'h00;
	logic                 end_of_input = 1'b0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [CP_W-1:0]      code_point;
	logic [1:0]           kind;
	logic [OUT_OFF_W-1:0] start_offset;
	logic [POS_W-1:0]     row;
	logic [POS_W-1:0]     column;
	logic                 last;

	utf8_decoder_with_position uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.kind(kind),
		.start_offset(start_offset),
		.row(row),
		.column(column),
		.last(last)
	);

	always #1 clk = ~clk;

	byte_req_t byte_queue[$];
	decoded_t  decoded_queue[$];
	decoded_t  step_results[2];
	int        step_n;

	logic [CP_W-1:0]        dec_acc       = '0;
	logic [1:0]             dec_pending   = 2'd0;
	logic [2:0]             dec_len       = LEN_NONE;
	logic [OFFSET_BITS-1:0] dec_offset    = '0;
	logic [OFFSET_BITS-1:0] dec_seq_start = '0;
	logic [POS_W-1:0]       dec_row       = POS_ONE;
	logic [POS_W-1:0]       dec_col       = POS_ONE;

	logic in_fire        = 1'b0;
	logic out_fire       = 1'b0;
	logic final_stretch  = 1'b0;
	logic long_hold_done = 1'b0;
	logic quiet_phase    = 1'b0;
	int   failures       = 0;
	int   results_seen   = 0;
	int   bytes_seen     = 0;
	int   ends_seen      = 0;
	int   idle_cycles    = 0;
	int   gap_left       = 0;
	int   calm_left      = 0;
	int   hold_left      = 0;
	int   ready_calm     = 0;

	function automatic logic value_fits(input logic [CP_W-1:0] v, input logic [2:0] len);
		case (len)
			LEN_TWO:   return v >= CP_MIN2;
			LEN_THREE: return v >= CP_MIN3 && (v < SURR_LO || v > SURR_HI);
			LEN_FOUR:  return v >= CP_MIN4 && v <= CP_MAX;
			default:   return 1'b0;
		endcase
	endfunction

	task automatic post_result(input logic [CP_W-1:0] cp, input kind_t k,
			input logic [OFFSET_BITS-1:0] start);
		step_results[step_n] = {cp, k, OUT_OFF_W'(start), dec_row, dec_col, 1'b0};
		step_n++;
		if (k == KIND_VALID && cp == CP_NEWLINE) begin
			if (dec_row != POS_MAX)
				dec_row++;
			dec_col = POS_ONE;
		end else if (k != KIND_END && dec_col != POS_MAX) begin
			dec_col++;
		end
	endtask

	task automatic clear_sequence;
		dec_pending = 2'd0;
		dec_len     = LEN_NONE;
		dec_acc     = '0;
	endtask

	task automatic decode_lead(input logic [7:0] b, input logic [OFFSET_BITS-1:0] pos);
		dec_seq_start = pos;
		if (b[7] == 1'b0) begin
			post_result(CP_W'(b), KIND_VALID, pos);
		end else if ((b & 8'hE0) == 8'hC0) begin
			dec_acc     = CP_W'(b & 8'h1F);
			dec_pending = 2'd1;
			dec_len     = LEN_TWO;
		end else if ((b & 8'hF0) == 8'hE0) begin
			dec_acc     = CP_W'(b & 8'h0F);
			dec_pending = 2'd2;
			dec_len     = LEN_THREE;
		end else if ((b & 8'hF8) == 8'hF0) begin
			dec_acc     = CP_W'(b & 8'h07);
			dec_pending = 2'd3;
			dec_len     = LEN_FOUR;
		end else begin
			post_result('0, KIND_ERROR, pos);
		end
	endtask

	task automatic decode_step(input logic [7:0] b, input logic eoi);
		decoded_t               r;
		logic [OFFSET_BITS-1:0] pos;
		step_n = 0;
		if (eoi) begin
			ends_seen++;
			if (dec_pending != 2'd0) begin
				post_result('0, KIND_ERROR, dec_seq_start);
				clear_sequence();
			end
			post_result('0, KIND_END, dec_offset);
		end else begin
			bytes_seen++;
			pos = dec_offset;
			dec_offset++;
			if (dec_pending == 2'd0) begin
				decode_lead(b, pos);
			end else if ((b & 8'hC0) == 8'h80) begin
				dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
				dec_pending--;
				if (dec_pending == 2'd0) begin
					if (value_fits(dec_acc, dec_len))
						post_result(dec_acc, KIND_VALID, dec_seq_start);
					else
						post_result('0, KIND_ERROR, dec_seq_start);
					clear_sequence();
				end
			end else begin
				post_result('0, KIND_ERROR, dec_seq_start);
				clear_sequence();
				decode_lead(b, pos);
			end
		end
		for (int i = 0; i < step_n; i++) begin
			r = step_results[i];
			r.last = (i == step_n - 1);
			decoded_queue.push_back(r);
		end
	endtask

	task automatic add_byte(input logic [7:0] b);
		byte_queue.push_back({b, 1'b0, 1'b0, quiet_phase});
	endtask

	task automatic add_end;
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		byte_queue.push_back({junk, 1'b1, 1'b0, quiet_phase});
	endtask

	task automatic add_drain;
		byte_queue.push_back({8'h00, 1'b0, 1'b1, 1'b0});
	endtask

	task automatic add_code_point(input logic [CP_W-1:0] cp, input logic [2:0] len);
		case (len)
			LEN_TWO: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			LEN_THREE: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			LEN_FOUR: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: add_byte({1'b0, cp[6:0]});
		endcase
	endtask

	always @(negedge clk) begin : drive_requests
		byte_req_t item;
		int        pick;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				item = byte_queue[0];
				if (item.drain) begin
					in_valid <= 1'b0;
					if (decoded_queue.size() == 0)
						item = byte_queue.pop_front();
				end else begin
					item = byte_queue.pop_front();
					final_stretch = item.quiet;
					in_valid     <= 1'b1;
					data_byte    <= item.data;
					end_of_input <= item.eoi;
					if (calm_left != 0) begin
						calm_left--;
					end else if (!item.quiet) begin
						pick = $urandom_range(0, 39);
						if (pick == 0)
							calm_left = 80;
						else if (pick < 10)
							gap_left = $urandom_range(1, 7);
					end
				end
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		int pick;
		if (!long_hold_done && results_seen >= HOLD_AFTER) begin
			long_hold_done = 1'b1;
			hold_left      = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (final_stretch || ready_calm != 0) begin
			if (ready_calm != 0)
				ready_calm--;
			out_ready <= 1'b1;
		end else begin
			pick = $urandom_range(0, 29);
			if (pick == 0) begin
				ready_calm = 60;
				out_ready <= 1'b1;
			end else if (pick < 7) begin
				hold_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		decoded_t want;
		decoded_t got;
		in_fire  = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		if (in_fire)
			decode_step(data_byte, end_of_input);
		if (out_fire) begin
			results_seen++;
			got = {code_point, kind_t'(kind), start_offset, row, column, last};
			if (decoded_queue.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none, actual cp=%0h kind=%0d off=%0h row=%0d col=%0d last=%0b",
					$time, got.cp, got.kind, got.start, got.row, got.column, got.last);
			end else begin
				want = decoded_queue.pop_front();
				if (got !== want) begin
					failures++;
					$display("%0t: mismatch, expected cp=%0h kind=%0d off=%0h row=%0d col=%0d last=%0b, actual cp=%0h kind=%0d off=%0h row=%0d col=%0d last=%0b",
						$time, want.cp, want.kind, want.start, want.row, want.column, want.last,
						got.cp, got.kind, got.start, got.row, got.column, got.last);
				end
			end
		end
		if (in_fire || out_fire)
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles, %0d results outstanding",
				$time, idle_cycles, decoded_queue.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : run_test
		int         pick;
		int         base;
		logic [2:0] len;
		logic       mid_drained;
		mid_drained = 1'b0;

		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(NEWLINE_BYTE);
		add_code_point(CP_W'(32'h7FF), LEN_TWO);
		add_code_point(CP_W'(32'h7F), LEN_TWO);
		add_code_point(SURR_LO, LEN_THREE);
		add_code_point(CP_MAX, LEN_FOUR);
		add_code_point(CP_MAX + CP_W'(1), LEN_FOUR);
		add_byte(8'hFF);
		add_byte(8'h80);
		add_byte(8'hC3);
		add_byte(8'h41);
		add_byte(8'hE2);
		add_byte(8'h82);
		add_end();
		add_end();
		add_byte(8'h41);
		add_drain();

		base = byte_queue.size();
		while (byte_queue.size() < base + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				add_byte(8'($urandom_range(0, 127)));
			end else if (pick < 45) begin
				add_code_point(CP_W'($urandom_range(32'h80, 32'h7FF)), LEN_TWO);
			end else if (pick < 60) begin
				add_code_point(CP_W'($urandom_range(32'h800, 32'hFFFF)), LEN_THREE);
			end else if (pick < 72) begin
				add_code_point(CP_W'($urandom_range(32'h10000, 32'h10FFFF)), LEN_FOUR);
			end else if (pick < 75) begin
				add_code_point(CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), LEN_FOUR);
			end else if (pick < 80) begin
				len = 3'($urandom_range(LEN_TWO, LEN_FOUR));
				case (len)
					LEN_TWO:   add_code_point(CP_W'($urandom_range(0, 32'h7F)), len);
					LEN_THREE: add_code_point(CP_W'($urandom_range(0, 32'h7FF)), len);
					default:   add_code_point(CP_W'($urandom_range(0, 32'hFFFF)), len);
				endcase
			end else if (pick < 85) begin
				add_byte(8'($urandom_range(8'hC0, 8'hF7)));
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 95) begin
				add_byte(NEWLINE_BYTE);
			end else if (pick < 97) begin
				add_code_point(CP_W'($urandom_range(SURR_LO, SURR_HI)), LEN_THREE);
			end else begin
				add_end();
			end
			if (!mid_drained && byte_queue.size() >= base + RANDOM_ITEMS / 2) begin
				add_drain();
				mid_drained = 1'b1;
			end
		end

		quiet_phase = 1'b1;
		repeat (SAT_RUN) add_byte(NEWLINE_BYTE);
		repeat (SAT_RUN) add_byte(LETTER_BYTE);
		add_code_point(CP_MAX, LEN_FOUR);
		add_byte(NEWLINE_BYTE);
		add_byte(8'hF0);
		add_end();
		add_end();

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (decoded_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Decoded %0d bytes and %0d end markers into %0d checked results.",
			bytes_seen, ends_seen, results_seen);
		$display("Covered all sequence lengths, malformed input, end markers, backpressure and a full drain.");
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
